// ===== hdl/u8seg_pkg.sv =====
// ----------------------------------------------------------------------------
// UTF-8 segmenter package
// Byte class masks, lead decoding and the command/status bundles shared by
// the controller and the datapath.
// ----------------------------------------------------------------------------
package u8seg_pkg;

  // Byte class masks and codes
  localparam logic [7:0] AsciiMask = 8'h80;
  localparam logic [7:0] ContMask  = 8'hC0;
  localparam logic [7:0] ContCode  = 8'h80;
  localparam logic [7:0] Lead2Mask = 8'hE0;
  localparam logic [7:0] Lead2Code = 8'hC0;
  localparam logic [7:0] Lead3Mask = 8'hF0;
  localparam logic [7:0] Lead3Code = 8'hE0;
  localparam logic [7:0] Lead4Mask = 8'hF8;
  localparam logic [7:0] Lead4Code = 8'hF0;

  typedef logic [2:0] len_t;

  // Controller to datapath
  typedef struct packed {
    logic step_en;  // accept the input byte, load the first piece
    logic pop_en;   // load the next buffered single byte
  } seg_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic any_piece;    // the presented byte yields at least one piece
    logic multi_piece;  // the presented byte yields more than one piece
    logic pend_last;    // the buffered byte at the head is the final one
  } seg_stat_t;

  function automatic len_t char_len(input logic [7:0] lead);
    len_t len;
    len = 3'd1;
    if ((lead & AsciiMask) == 8'h00)           len = 3'd1;
    else if ((lead & Lead2Mask) == Lead2Code)  len = 3'd2;
    else if ((lead & Lead3Mask) == Lead3Code)  len = 3'd3;
    else if ((lead & Lead4Mask) == Lead4Code)  len = 3'd4;
    return len;
  endfunction

  function automatic logic is_cont(input logic [7:0] b);
    return (b & ContMask) == ContCode;
  endfunction

endpackage

// ===== hdl/u8seg_if.sv =====
// ----------------------------------------------------------------------------
// UTF-8 segmenter channels
// Valid/ready channels for the byte stream and the piece stream.
// ----------------------------------------------------------------------------
interface u8seg_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       text_last;

  modport source (output valid, data_byte, text_last, input ready);
  modport sink   (input valid, data_byte, text_last, output ready);
endinterface

interface u8seg_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] piece_data;
  logic [2:0]  piece_length;
  logic        run_last;
  logic        text_end;

  modport source (output valid, piece_data, piece_length, run_last, text_end,
                  input ready);
  modport sink   (input valid, piece_data, piece_length, run_last, text_end,
                  output ready);
endinterface

// ===== hdl/utf8_char_segmenter.sv =====
// ----------------------------------------------------------------------------
// UTF-8 character segmenter
// Splits a byte stream into pieces of one whole character or single bytes.
// ----------------------------------------------------------------------------
// Usage:
//   in_i carries one text byte per request with text_last on the final byte.
//   out_o carries pieces: up to four bytes packed from bit 0, their count,
//   run_last on the last piece a byte causes and text_end on the text's end.
//   A lead byte (110x, 1110x, 11110x) opens a character; its bytes are held
//   until the last continuation byte arrives and go out as one piece.
//   A broken or early-ended character goes out as single bytes.
// Timing:
//   The first piece of a byte enters the output register in the cycle after
//   the byte is accepted. A clean stream, each byte yielding at most one
//   piece, runs at one byte per cycle unless out_o.ready stalls it. A byte
//   with more pieces (up to four) takes no new byte until its buffered bytes
//   flush, one per cycle unless stalled, through the single output register.
// Reset: clears the held count and the output valid; nothing is held.
// Stall: while a piece waits on out_o.ready, no byte is accepted and the
//   piece and its flags hold; the block resumes in the cycle it is taken.
// ----------------------------------------------------------------------------
module utf8_char_segmenter (
  input  logic        clk_i,
  input  logic        rst_ni,
  u8seg_in_if.sink    in_i,
  u8seg_out_if.source out_o
);
  import u8seg_pkg::*;

  seg_cmd_t  cmd;
  seg_stat_t stat;

  // Controller: request handshake, output valid, flush sequencing
  u8seg_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  // Datapath: held character, byte decode, flush buffer, piece register
  u8seg_dp u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .data_byte_i    (in_i.data_byte),
    .text_last_i    (in_i.text_last),
    .cmd_i          (cmd),
    .stat_o         (stat),
    .piece_data_o   (out_o.piece_data),
    .piece_length_o (out_o.piece_length),
    .run_last_o     (out_o.run_last),
    .text_end_o     (out_o.text_end)
  );

endmodule

// ===== hdl/u8seg_ctrl.sv =====
// ----------------------------------------------------------------------------
// UTF-8 segmenter controller
// Sequences request acceptance and the flush of buffered single bytes.
// ----------------------------------------------------------------------------
module u8seg_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  input  u8seg_pkg::seg_stat_t stat_i,
  output u8seg_pkg::seg_cmd_t  cmd_o
);
  import u8seg_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE  = 2'b01,
    ST_FLUSH = 2'b10
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   out_free;

  assign out_free = !out_valid_q || out_ready_i;

  always_comb begin
    state_d       = state_q;
    out_valid_d   = out_valid_q && !out_ready_i;
    in_ready_o    = 1'b0;
    cmd_o.step_en = 1'b0;
    cmd_o.pop_en  = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o    = out_free;
        cmd_o.step_en = in_valid_i && out_free;
        if (cmd_o.step_en) begin
          if (stat_i.any_piece) out_valid_d = 1'b1;
          if (stat_i.multi_piece) state_d = ST_FLUSH;
        end
      end
      ST_FLUSH: begin
        cmd_o.pop_en = out_free;
        if (out_free) begin
          out_valid_d = 1'b1;
          if (stat_i.pend_last) state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

// ===== hdl/u8seg_dp.sv =====
// ----------------------------------------------------------------------------
// UTF-8 segmenter datapath
// Holds the open character, decodes each byte and drives the piece register.
// ----------------------------------------------------------------------------
module u8seg_dp (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic [7:0]           data_byte_i,
  input  logic                 text_last_i,
  input  u8seg_pkg::seg_cmd_t  cmd_i,
  output u8seg_pkg::seg_stat_t stat_o,
  output logic [31:0]          piece_data_o,
  output logic [2:0]           piece_length_o,
  output logic                 run_last_o,
  output logic                 text_end_o
);
  import u8seg_pkg::*;

  // Open character
  logic [7:0] held_q [3];
  logic [1:0] held_cnt_q, held_cnt_d;
  len_t       exp_len_q, exp_len_d;

  // Buffered single bytes still to send
  logic [7:0] pend_q [3];
  logic [1:0] pend_cnt_q;  // number buffered minus one
  logic [1:0] pend_idx_q;
  logic       fl_last_q;

  // Piece register
  logic [31:0] data_q;
  logic [2:0]  len_q;
  logic        run_last_q, text_end_q;

  logic [7:0]  b;
  logic        cont, fresh, complete, join_c, keep_c, emit_b;
  len_t        len, n_single, n_piece;
  logic [7:0]  list [4];
  logic [31:0] joined;
  logic [7:0]  pend_head;

  assign b = data_byte_i;

  always_comb begin
    cont     = is_cont(b);
    len      = char_len(b);
    complete = ({1'b0, held_cnt_q} + 3'd1) >= exp_len_q;
    fresh    = (held_cnt_q == 2'd0) || !cont;
    join_c   = !fresh && complete;
    keep_c   = !fresh && !complete && !text_last_i;
    // An early-ended character sends the new byte singly too; a broken one does unless that byte opens a new character
    emit_b   = fresh ? ((len == 3'd1) || text_last_i) : text_last_i;
    n_single = {1'b0, held_cnt_q} + {2'b00, emit_b};
    n_piece  = join_c ? 3'd1 : (keep_c ? 3'd0 : n_single);

    list[0] = (held_cnt_q > 2'd0) ? held_q[0] : b;
    list[1] = (held_cnt_q > 2'd1) ? held_q[1] : b;
    list[2] = (held_cnt_q > 2'd2) ? held_q[2] : b;
    list[3] = b;

    joined[7:0]   = list[0];
    joined[15:8]  = (held_cnt_q > 2'd1) ? held_q[1] : ((held_cnt_q == 2'd1) ? b : 8'h00);
    joined[23:16] = (held_cnt_q > 2'd2) ? held_q[2] : ((held_cnt_q == 2'd2) ? b : 8'h00);
    joined[31:24] = (held_cnt_q == 2'd3) ? b : 8'h00;

    held_cnt_d = held_cnt_q;
    exp_len_d  = exp_len_q;
    if (keep_c) begin
      held_cnt_d = held_cnt_q + 2'd1;
    end else if (fresh && !emit_b) begin
      held_cnt_d = 2'd1;
      exp_len_d  = len;
    end else begin
      held_cnt_d = 2'd0;
      exp_len_d  = 3'd0;
    end

    case (pend_idx_q)
      2'd0:    pend_head = pend_q[0];
      2'd1:    pend_head = pend_q[1];
      default: pend_head = pend_q[2];
    endcase

    stat_o.any_piece   = n_piece != 3'd0;
    stat_o.multi_piece = n_piece > 3'd1;
    stat_o.pend_last   = pend_idx_q == pend_cnt_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_cnt_q <= 2'd0;
      exp_len_q  <= 3'd0;
      pend_cnt_q <= 2'd0;
      pend_idx_q <= 2'd0;
    end else if (cmd_i.step_en) begin
      held_cnt_q <= held_cnt_d;
      exp_len_q  <= exp_len_d;
      pend_cnt_q <= 2'(n_piece - 3'd2);
      pend_idx_q <= 2'd0;
    end else if (cmd_i.pop_en) begin
      pend_idx_q <= pend_idx_q + 2'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.step_en) begin
      fl_last_q <= text_last_i;
      pend_q[0] <= list[1];
      pend_q[1] <= list[2];
      pend_q[2] <= list[3];
      if (keep_c) begin
        case (held_cnt_q)
          2'd1:    held_q[1] <= b;
          default: held_q[2] <= b;
        endcase
      end else if (fresh && !emit_b) begin
        held_q[0] <= b;
      end
      if (n_piece != 3'd0) begin
        data_q     <= join_c ? joined : {24'h000000, list[0]};
        len_q      <= join_c ? ({1'b0, held_cnt_q} + 3'd1) : 3'd1;
        run_last_q <= n_piece == 3'd1;
        text_end_q <= text_last_i && (n_piece == 3'd1);
      end
    end else if (cmd_i.pop_en) begin
      data_q     <= {24'h000000, pend_head};
      len_q      <= 3'd1;
      run_last_q <= stat_o.pend_last;
      text_end_q <= stat_o.pend_last && fl_last_q;
    end
  end

  assign piece_data_o   = data_q;
  assign piece_length_o = len_q;
  assign run_last_o     = run_last_q;
  assign text_end_o     = text_end_q;

endmodule

// ===== hdl/u8seg_chk.sv =====
// ----------------------------------------------------------------------------
// UTF-8 segmenter port checker
// Port-level properties of the segmenter, bound to the top level.
// ----------------------------------------------------------------------------
module u8seg_chk (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_i,
  input logic [7:0]  data_byte_i,
  input logic        text_last_i,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic [31:0] piece_data_i,
  input logic [2:0]  piece_length_i,
  input logic        run_last_i,
  input logic        text_end_i
);

  // Hold a stalled piece
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("piece dropped while stalled");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=>
      $stable(piece_data_i) && $stable(piece_length_i) &&
      $stable(run_last_i) && $stable(text_end_i))
    else $error("stalled piece changed");

  // Hold off requests while more pieces of the same byte follow
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !run_last_i |-> !in_ready_i)
    else $error("request accepted in the middle of a flush");

  // A final or single-byte request always yields a piece next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i && (text_last_i || !data_byte_i[7]) |=> out_valid_i)
    else $error("no piece after a final or single byte");

endmodule

bind utf8_char_segmenter u8seg_chk u_chk (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid_i     (in_i.valid),
  .in_ready_i     (in_i.ready),
  .data_byte_i    (in_i.data_byte),
  .text_last_i    (in_i.text_last),
  .out_valid_i    (out_o.valid),
  .out_ready_i    (out_o.ready),
  .piece_data_i   (out_o.piece_data),
  .piece_length_i (out_o.piece_length),
  .run_last_i     (out_o.run_last),
  .text_end_i     (out_o.text_end)
);
